/* rtl/core/pci_pkg.sv */
// Shared types and constants of the palette color indexer.
// Beat layouts of both channels and the token passed along the cell chain.
// No dependencies.
`default_nettype none

package pci_pkg;

    localparam int COLOR_W = 24;
    localparam logic [7:0] COLOR_MASK = 8'hff;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        start_of_image;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0] color_index;
        logic       added;
        logic       overflow;
    } index_beat_t;

    // One pixel in flight through the chain.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic               added;
        logic [COLOR_W-1:0] color;
    } token_t;

    // blue:green:red, alpha dropped
    function automatic logic [COLOR_W-1:0] rgb_of(input logic [31:0] word);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = word[7:0] & COLOR_MASK;
        g = word[15:8] & COLOR_MASK;
        b = word[23:16] & COLOR_MASK;
        return {b, g, r};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pci_cell.sv */
// One palette cell: holds one palette entry and one pipeline slot of the chain.
// Depends on pci_pkg (token_t, COLOR_W).
`default_nettype none

module pci_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic [CNT_W-1:0]    count,
    input  wire pci_pkg::token_t     tok_in,
    input  wire logic [IDX_W-1:0]    idx_in,
    output pci_pkg::token_t          tok_out,
    output logic [IDX_W-1:0]         idx_out,
    output logic                     append
);

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] SLOT_IDX = IDX_W'(INDEX);

    logic [pci_pkg::COLOR_W-1:0] entry_reg;
    pci_pkg::token_t             tok_reg;
    pci_pkg::token_t             tok_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic                        searching;
    logic                        hit;
    logic                        fill;

    assign searching = tok_in.valid && !tok_in.found;
    assign hit       = searching && (SLOT < count) && (entry_reg == tok_in.color);
    assign fill      = searching && (SLOT == count);

    always_comb
    begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (hit || fill)
        begin
            tok_next.found = 1'b1;
            idx_next       = SLOT_IDX;
        end
        if (fill)
        begin
            tok_next.added = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg <= idx_next;
            if (fill)
            begin
                entry_reg <= tok_in.color;
            end
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;
    assign append  = fill && advance;

endmodule

`default_nettype wire

/* rtl/core/palette_color_indexer.sv */
// Palette color indexer top level: input register, chain of palette cells, output register.
// Depends on pci_pkg and pci_cell.
//
//   port group    dir  handshake              payload
//   pixel_*       in   pixel_valid/stall      pixel_beat  (pixel_word, start_of_image)
//   index_*       out  index_valid/stall      index_beat  (color_index, added, overflow)
//
// One pixel enters per cycle while pixel_stall is low; each result passes through the input
// register (loaded on the accepting edge), one register per cell and the output register.
// A beat with start_of_image is held at the port until the chain is empty; it then
// restarts at index 0. A stall on a valid result freezes the whole chain.
// Reset empties the palette at once; entry contents are never cleared.
`default_nettype none

module palette_color_indexer #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pixel_valid,
    output logic                      pixel_stall,
    input  wire pci_pkg::pixel_beat_t pixel_beat,
    output logic                      index_valid,
    input  wire logic                 index_stall,
    output pci_pkg::index_beat_t      index_beat
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int OCC_W = $clog2(PALETTE_ENTRIES + 2);

    pci_pkg::token_t      tok [PALETTE_ENTRIES+1];
    logic [IDX_W-1:0]     idx [PALETTE_ENTRIES+1];
    logic [PALETTE_ENTRIES-1:0] app_vec;

    logic                        head_valid_reg;
    logic [pci_pkg::COLOR_W-1:0] head_color_reg;
    logic                 head_start_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_view;
    logic [OCC_W-1:0]     occ_reg;
    logic                 index_valid_reg;
    pci_pkg::index_beat_t index_beat_reg;
    pci_pkg::index_beat_t index_beat_next;

    logic advance;
    logic accept;
    logic retire;
    logic any_app;

    assign advance     = !index_valid_reg || !index_stall;
    assign pixel_stall = !advance || (pixel_beat.start_of_image && (occ_reg != '0));
    assign accept      = pixel_valid && !pixel_stall;
    assign retire      = advance && tok[PALETTE_ENTRIES].valid;
    assign any_app     = |app_vec;

    // a start beat only sits in the head register with the chain empty
    assign count_view = (head_valid_reg && head_start_reg) ? '0 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            head_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_color_reg <= pci_pkg::rgb_of(pixel_beat.pixel_word);
            head_start_reg <= pixel_beat.start_of_image;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance && any_app)
        begin
            count_reg <= count_view + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (accept && !retire)
        begin
            occ_reg <= occ_reg + OCC_W'(1);
        end
        else if (retire && !accept)
        begin
            occ_reg <= occ_reg - OCC_W'(1);
        end
    end

    assign tok[0] = '{valid: head_valid_reg, found: 1'b0, added: 1'b0, color: head_color_reg};
    assign idx[0] = '0;

    for (genvar k = 0; k < PALETTE_ENTRIES; k++)
    begin : g_cell
        pci_cell #(
            .INDEX (k),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .count   (count_view),
            .tok_in  (tok[k]),
            .idx_in  (idx[k]),
            .tok_out (tok[k+1]),
            .idx_out (idx[k+1]),
            .append  (app_vec[k])
        );
    end

    always_comb
    begin
        index_beat_next.added = tok[PALETTE_ENTRIES].added;
        if (tok[PALETTE_ENTRIES].found)
        begin
            index_beat_next.color_index = 8'(idx[PALETTE_ENTRIES]);
            index_beat_next.overflow    = 1'b0;
        end
        else
        begin
            index_beat_next.color_index = '0;
            index_beat_next.overflow    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            index_valid_reg <= tok[PALETTE_ENTRIES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_beat_reg <= index_beat_next;
        end
    end

    assign index_valid = index_valid_reg;
    assign index_beat  = index_beat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PALETTE_ENTRIES))
        else $error("palette count beyond capacity");

    a_one_append: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(app_vec))
        else $error("more than one cell appended in a cycle");

    a_start_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && head_start_reg) |-> (occ_reg == OCC_W'(1)))
        else $error("start beat entered a busy chain");

    a_start_appends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && head_valid_reg && head_start_reg) |-> app_vec[0])
        else $error("start beat did not restart the palette");

    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (index_valid && index_beat.overflow) |->
            (!index_beat.added && (index_beat.color_index == 8'd0)))
        else $error("overflow result with index or added flag");

endmodule

`default_nettype wire

/* bench/palette_color_indexer_chk.sv */
// Result checker for the palette color indexer: watches both channels, keeps its own palette,
// predicts each index beat and compares it field by field with the block's output.
// Depends on pci_pkg.
module palette_color_indexer_chk #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    input  logic                 pixel_stall,
    input  pci_pkg::pixel_beat_t pixel_beat,
    input  logic                 index_valid,
    input  logic                 index_stall,
    input  pci_pkg::index_beat_t index_beat,
    output int                   fail_count,
    output int                   pending,
    output int                   pixels_seen,
    output int                   colors_appended,
    output int                   overflows_seen
);

    localparam int MAX_REPORTS = 40;

    logic [23:0]          palette_colors [PALETTE_ENTRIES];
    int unsigned          palette_len = 0;
    pci_pkg::index_beat_t expected_indices [$];
    pci_pkg::index_beat_t oldest;
    int                   results_seen = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: result %0d: %s", $time, results_seen, what);
    endtask

    function automatic pci_pkg::index_beat_t index_pixel(input pci_pkg::pixel_beat_t px);
        logic [23:0]          color;
        pci_pkg::index_beat_t res;
        bit                   found;
        color = px.pixel_word[23:0];
        res   = '0;
        found = 1'b0;
        if (px.start_of_image)
            palette_len = 0;
        for (int unsigned i = 0; i < palette_len; i++)
        begin
            if (palette_colors[i] == color)
            begin
                res.color_index = 8'(i);
                found = 1'b1;
                break;
            end
        end
        if (!found)
        begin
            if (palette_len < PALETTE_ENTRIES)
            begin
                palette_colors[palette_len] = color;
                res.color_index = 8'(palette_len);
                res.added = 1'b1;
                palette_len++;
            end
            else
            begin
                res.overflow = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_len = 0;
            expected_indices.delete();
            results_seen = 0;
            fail_count = 0;
            pixels_seen = 0;
            colors_appended = 0;
            overflows_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (index_valid && !index_stall)
            begin
                if (expected_indices.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat index=%0d added=%0b overflow=%0b",
                        index_beat.color_index, index_beat.added, index_beat.overflow));
                end
                else
                begin
                    oldest = expected_indices.pop_front();
                    if (index_beat.color_index !== oldest.color_index)
                        report_mismatch($sformatf("color_index %0d, expected %0d",
                            index_beat.color_index, oldest.color_index));
                    if (index_beat.added !== oldest.added)
                        report_mismatch($sformatf("added %0b, expected %0b",
                            index_beat.added, oldest.added));
                    if (index_beat.overflow !== oldest.overflow)
                        report_mismatch($sformatf("overflow %0b, expected %0b",
                            index_beat.overflow, oldest.overflow));
                end
                results_seen++;
            end
            if (pixel_valid && !pixel_stall)
            begin
                oldest = index_pixel(pixel_beat);
                expected_indices.push_back(oldest);
                pixels_seen++;
                if (oldest.added)
                    colors_appended++;
                if (oldest.overflow)
                    overflows_seen++;
            end
            pending <= expected_indices.size();
        end
    end

endmodule

/* bench/palette_color_indexer_tb.sv */
// Testbench top for the palette color indexer: clock, reset, pixel stimulus and stall pattern,
// watchdog and verdict. Depends on pci_pkg, palette_color_indexer and palette_color_indexer_chk.
module palette_color_indexer_tb;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PIXEL_TARGET    = 1850;
    localparam int IDLE_PCT        = 22;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = PALETTE_ENTRIES + 8;
    localparam int FULL_IMAGE_ROOM = PALETTE_ENTRIES + 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_stall;
    pci_pkg::pixel_beat_t pixel_beat = '0;
    logic                 index_valid;
    logic                 index_stall = 1'b0;
    pci_pkg::index_beat_t index_beat;

    int          fail_count;
    int          pending;
    int          pixels_seen;
    int          colors_appended;
    int          overflows_seen;
    int          pixel_count = 0;
    int          image_count = 0;
    bit          steady = 1'b0;
    logic [23:0] image_colors [$];

    palette_color_indexer #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel_beat (pixel_beat),
        .index_valid(index_valid),
        .index_stall(index_stall),
        .index_beat (index_beat)
    );

    palette_color_indexer_chk #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_beat     (pixel_beat),
        .index_valid    (index_valid),
        .index_stall    (index_stall),
        .index_beat     (index_beat),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_seen    (pixels_seen),
        .colors_appended(colors_appended),
        .overflows_seen (overflows_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            index_stall <= 1'b0;
        else
            index_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (index_valid && !index_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("palette_color_indexer verification failed");
        $finish;
    end

    task automatic send_pixel(input logic [31:0] word, input logic sof);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_beat <= {word, sof};
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pixel_count++;
        if (sof)
            image_count++;
    endtask

    // few colors, heavy reuse; restart=0 continues the previous palette
    task automatic send_small_image(input bit restart);
        int          n_colors;
        int          n_pixels;
        logic [23:0] color;
        image_colors.delete();
        n_colors = $urandom_range(1, 24);
        repeat (n_colors) image_colors.push_back(24'($urandom));
        n_pixels = $urandom_range(20, 80);
        for (int p = 0; p < n_pixels; p++)
        begin
            if ($urandom_range(9) == 0)
                color = 24'($urandom);
            else
                color = image_colors[$urandom_range(n_colors - 1)];
            send_pixel({8'($urandom), color}, restart && p == 0);
        end
    endtask

    // fills the palette, then mixes known colors with new ones that overflow
    task automatic send_full_image();
        logic [23:0] base;
        logic [23:0] stride;
        logic [23:0] color;
        int          n_new;
        int          n_tail;
        image_colors.delete();
        base   = 24'($urandom);
        stride = 24'($urandom) | 24'h1;   // odd stride keeps colors distinct
        n_new  = PALETTE_ENTRIES + $urandom_range(1, 12);
        for (int k = 0; k < n_new; k++)
        begin
            color = base + stride * 24'(k);
            send_pixel({8'($urandom), color}, k == 0);
            if (k < PALETTE_ENTRIES)
                image_colors.push_back(color);
            if ($urandom_range(7) == 0)
                send_pixel({8'($urandom), image_colors[$urandom_range(image_colors.size() - 1)]},
                    1'b0);
        end
        n_tail = $urandom_range(16, 40);
        for (int t = 0; t < n_tail; t++)
        begin
            case ($urandom_range(3))
                0: color = image_colors[PALETTE_ENTRIES - 1];
                1: color = image_colors[$urandom_range(PALETTE_ENTRIES - 1)];
                default: color = base + stride * 24'(n_new + t);
            endcase
            send_pixel({8'($urandom), color}, 1'b0);
        end
    endtask

    task automatic send_noise();
        int n_pixels;
        n_pixels = $urandom_range(10, 40);
        repeat (n_pixels) send_pixel($urandom, $urandom_range(19) == 0);
    endtask

    initial
    begin
        int kind;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // palette empty after reset, no start flag needed
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h00FF_FFFF, 1'b0);   // alpha differs only
        send_pixel(32'hAB00_0000, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'hFF34_5678, 1'b0);
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'h0000_0100, 1'b0);
        send_pixel(32'h0001_0000, 1'b0);
        send_pixel(32'h0100_0000, 1'b0);
        send_pixel(32'h0034_5678, 1'b1);   // restart on a known color
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b1);   // back-to-back restarts
        send_pixel(32'h8080_8080, 1'b0);
        send_pixel(32'h7F7F_7F7F, 1'b0);
        send_pixel(32'h7F7F_7F7F, 1'b0);

        steady = 1'b1;
        send_full_image();
        steady = 1'b0;

        while (pixel_count < PIXEL_TARGET)
        begin
            kind = $urandom_range(15);
            if (kind < 2 && pixel_count + FULL_IMAGE_ROOM < PIXEL_TARGET)
                send_full_image();
            else if (kind < 13)
                send_small_image(1'b1);
            else if (kind < 14)
                send_small_image(1'b0);
            else
                send_noise();
        end
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pixels in %0d restarted images indexed, %0d colors appended",
            pixels_seen, image_count, colors_appended);
        $display("%0d new colors hit a full palette, %0d mismatches", overflows_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("palette_color_indexer verification clean");
        else
            $display("palette_color_indexer verification failed");
        $finish;
    end

endmodule
